// ----- rtl/irpp_pkg.sv -----
// ----------------------------------------------------------------------------
// irpp_pkg
// Types and constants shared by the infrared pulse pair capture block.
// ----------------------------------------------------------------------------
package irpp_pkg;

	localparam int unsigned TIME_W = 16;
	localparam int unsigned COUNT_W = 8;
	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 16'd60000;
	localparam logic [TIME_W-1:0] TICKS_MAX = '1;

	// Queue between the front and the back.
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QAW = $clog2(QDEPTH);
	localparam int unsigned QCW = $clog2(QDEPTH + 1);

	// Input command codes.
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_EDGE = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_EDGE = 2'd1,
		OP_TICK = 2'd2
	} op_e_t;

	typedef struct packed {
		op_e_t op;
		logic tag;
	} entry_t;

	typedef struct packed {
		logic [TIME_W-1:0] low_ticks;
		logic [TIME_W-1:0] high_ticks;
		logic entry_valid;
		logic last;
	} result_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_ARMED = 3'b010,
		PH_CAPTURE = 3'b100
	} phase_t;

endpackage

// ----- rtl/ir_pulse_pair_capture.sv -----
// A result is offered from the output register; the operation that causes it first waits
// in the operation queue and is then processed by the capture back end.
// Throughput: one input item per cycle when neither the queue nor the output stalls.
// A two-entry operation queue and the output register let each side stall on its own; a
// stalled result holds every queued operation, and the input stalls once both slots fill.
// Reset (arst_n low, asynchronous): capture idle, queue and output empty, idle_timeout 60000.
// ----------------------------------------------------------------------------
// ir_pulse_pair_capture
// Top level: front classifier, operation queue and capture back end.
// ----------------------------------------------------------------------------
module ir_pulse_pair_capture #(
	parameter int unsigned MAX_PULSES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [irpp_pkg::TIME_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] cmd,
	input logic level_high,
	output logic out_valid,
	input logic out_stall,
	output logic [irpp_pkg::TIME_W-1:0] low_ticks,
	output logic [irpp_pkg::TIME_W-1:0] high_ticks,
	output logic entry_valid,
	output logic last
);
	import irpp_pkg::*;

	logic push, pop, q_valid, q_full;
	entry_t push_entry, q_entry;
	logic [QCW-1:0] q_count;
	result_t result;

	irpp_front u_front (
		.in_valid(in_valid),
		.cmd(cmd),
		.level_high(level_high),
		.q_full(q_full),
		.in_stall(in_stall),
		.push(push),
		.push_entry(push_entry)
	);

	irpp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.q_valid(q_valid),
		.q_full(q_full),
		.q_entry(q_entry),
		.q_count(q_count)
	);

	irpp_back #(
		.MAX_PULSES(MAX_PULSES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.q_valid(q_valid),
		.q_entry(q_entry),
		.pop(pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_result(result)
	);

	assign low_ticks = result.low_ticks;
	assign high_ticks = result.high_ticks;
	assign entry_valid = result.entry_valid;
	assign last = result.last;

`ifndef ASSERT_OFF
	// A bare end marker always closes the capture and carries no durations.
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !entry_valid |-> last && low_ticks == '0 && high_ticks == '0)
		else $error("bare end marker malformed");

	// The queue never holds more operations than it has slots.
	a_qcount: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCW'(QDEPTH))
		else $error("operation queue overflow");

	// A queued operation is drained in any cycle in which the output holds no result.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && !out_valid |-> pop)
		else $error("back end idle with work queued");
`endif

endmodule

// ----- rtl/irpp_front.sv -----
// ----------------------------------------------------------------------------
// irpp_front
// Accepts input transfers and classifies the command into an operation.
// ----------------------------------------------------------------------------
module irpp_front (
	input logic in_valid,
	input logic [1:0] cmd,
	input logic level_high,
	input logic q_full,
	output logic in_stall,
	output logic push,
	output irpp_pkg::entry_t push_entry
);
	import irpp_pkg::*;

	logic known;

	assign in_stall = q_full;

	always_comb begin
		known = 1'b1;
		push_entry.tag = level_high;
		case (cmd)
			CMD_START: push_entry.op = OP_START;
			CMD_EDGE: push_entry.op = OP_EDGE;
			CMD_TICK: push_entry.op = OP_TICK;
			default: begin
				// The unused code is taken and dropped here.
				push_entry.op = OP_TICK;
				known = 1'b0;
			end
		endcase
	end

	assign push = in_valid && !q_full && known;

endmodule

// ----- rtl/irpp_queue.sv -----
// ----------------------------------------------------------------------------
// irpp_queue
// Short FIFO of classified operations between the front and the back.
// ----------------------------------------------------------------------------
module irpp_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input irpp_pkg::entry_t push_entry,
	input logic pop,
	output logic q_valid,
	output logic q_full,
	output irpp_pkg::entry_t q_entry,
	output logic [irpp_pkg::QCW-1:0] q_count
);
	import irpp_pkg::*;

	entry_t slots_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign q_valid = (count_q != '0);
	assign q_full = (count_q == QCW'(QDEPTH));
	assign q_entry = slots_q[rd_ptr_q];
	assign q_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ----- rtl/irpp_back.sv -----
// ----------------------------------------------------------------------------
// irpp_back
// Capture state machine: tick counting, pulse pairing and result register.
// ----------------------------------------------------------------------------
module irpp_back #(
	parameter int unsigned MAX_PULSES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [irpp_pkg::TIME_W-1:0] cfg_data,
	input logic q_valid,
	input irpp_pkg::entry_t q_entry,
	output logic pop,
	input logic out_stall,
	output logic out_valid,
	output irpp_pkg::result_t out_result
);
	import irpp_pkg::*;

	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(2 * MAX_PULSES);

	logic [TIME_W-1:0] timeout_q;
	phase_t phase_q, phase_nx;
	logic [TIME_W-1:0] elapsed_q, elapsed_nx, ticks_inc;
	logic [COUNT_W-1:0] count_q, count_nx, count_inc;
	logic pend_valid_q, pend_valid_nx;
	logic [TIME_W-1:0] pend_dur_q, pend_dur_nx;
	logic pend_tag_q, pend_tag_nx;
	logic out_valid_q;
	result_t result_q, res;
	logic has_res;
	logic full;

	assign pop = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_result = result_q;

	assign ticks_inc = (elapsed_q == TICKS_MAX) ? elapsed_q : elapsed_q + TIME_W'(1);
	assign count_inc = count_q + COUNT_W'(1);
	assign full = (count_inc >= FULL_COUNT);

	always_comb begin
		phase_nx = phase_q;
		elapsed_nx = elapsed_q;
		count_nx = count_q;
		pend_valid_nx = pend_valid_q;
		pend_dur_nx = pend_dur_q;
		pend_tag_nx = pend_tag_q;
		has_res = 1'b0;
		res = '0;
		case (q_entry.op)
			OP_START: begin
				phase_nx = PH_ARMED;
				elapsed_nx = '0;
				count_nx = '0;
				pend_valid_nx = 1'b0;
				pend_dur_nx = '0;
				pend_tag_nx = 1'b0;
			end
			OP_EDGE: begin
				if (phase_q == PH_ARMED) begin
					elapsed_nx = '0;
					phase_nx = PH_CAPTURE;
				end else if (phase_q == PH_CAPTURE) begin
					elapsed_nx = '0;
					count_nx = count_inc;
					if ((count_q == '0) && q_entry.tag) begin
						has_res = 1'b1;
						res.high_ticks = elapsed_q;
					end else if (pend_valid_q) begin
						has_res = 1'b1;
						pend_valid_nx = 1'b0;
						if (!pend_tag_q && q_entry.tag) begin
							res.low_ticks = pend_dur_q;
							res.high_ticks = elapsed_q;
						end
					end else if (full) begin
						// The record that fills the store is itself the leftover.
						has_res = 1'b1;
						res.low_ticks = elapsed_q;
					end else begin
						pend_valid_nx = 1'b1;
						pend_dur_nx = elapsed_q;
						pend_tag_nx = q_entry.tag;
					end
					if (has_res) begin
						res.entry_valid = 1'b1;
						res.last = full;
					end
					if (full) begin
						phase_nx = PH_IDLE;
						pend_valid_nx = 1'b0;
					end
				end
			end
			OP_TICK: begin
				if (phase_q == PH_CAPTURE) begin
					elapsed_nx = ticks_inc;
					if (ticks_inc >= timeout_q) begin
						has_res = 1'b1;
						res.last = 1'b1;
						res.entry_valid = pend_valid_q;
						res.low_ticks = pend_valid_q ? pend_dur_q : '0;
						pend_valid_nx = 1'b0;
						phase_nx = PH_IDLE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			phase_q <= PH_IDLE;
			elapsed_q <= '0;
			count_q <= '0;
			pend_valid_q <= 1'b0;
			pend_dur_q <= '0;
			pend_tag_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				timeout_q <= cfg_data;
			end
			if (pop) begin
				phase_q <= phase_nx;
				elapsed_q <= elapsed_nx;
				count_q <= count_nx;
				pend_valid_q <= pend_valid_nx;
				pend_dur_q <= pend_dur_nx;
				pend_tag_q <= pend_tag_nx;
			end
			if (pop && has_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && has_res) begin
			result_q <= res;
		end
	end

endmodule

// ----- tb/ir_pulse_pair_capture_tb.sv -----
// ----------------------------------------------------------------------------
// ir_pulse_pair_capture_tb
// Self-checking bench for the infrared pulse pair capture block. A queue of
// commands feeds a driver; a monitor predicts the pulse pairs of every input
// transfer and compares each result transfer with the oldest prediction.
// Phases vary the idle timeout and the amount of idling on both sides.
// ----------------------------------------------------------------------------
module ir_pulse_pair_capture_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import irpp_pkg::*;

	localparam int PULSE_LIMIT = 64;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic tag;
	} ir_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [TIME_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = CMD_TICK;
	logic level_high = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [TIME_W-1:0] low_ticks;
	logic [TIME_W-1:0] high_ticks;
	logic entry_valid;
	logic last;

	ir_item_t pending_items[$];
	result_t expected_pairs[$];
	int unsigned queued_count = 0;
	int unsigned accepted_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// Predicted state of the capture.
	phase_t cap_phase = PH_IDLE;
	logic [TIME_W-1:0] idle_limit = TIMEOUT_RESET;
	logic [TIME_W-1:0] tick_count = '0;
	logic [COUNT_W-1:0] stored_records = '0;
	logic held_valid = 1'b0;
	logic [TIME_W-1:0] held_ticks = '0;
	logic held_high = 1'b0;

	ir_pulse_pair_capture #(
		.MAX_PULSES(PULSE_LIMIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.level_high(level_high),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.low_ticks(low_ticks),
		.high_ticks(high_ticks),
		.entry_valid(entry_valid),
		.last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Ends the capture: a waiting record leaves as (duration, 0), else a bare marker.
	task automatic close_capture();
		result_t r;
		r = '0;
		r.last = 1'b1;
		if (held_valid) begin
			r.low_ticks = held_ticks;
			r.entry_valid = 1'b1;
		end
		expected_pairs.push_back(r);
		held_valid = 1'b0;
		cap_phase = PH_IDLE;
	endtask

	task automatic predict_capture(input logic [1:0] c, input logic tag);
		logic [TIME_W-1:0] d;
		logic first_rec;
		logic store_full;
		logic have_pair;
		result_t r;
		r = '0;
		have_pair = 1'b0;
		case (c)
			CMD_START: begin
				cap_phase = PH_ARMED;
				tick_count = '0;
				stored_records = '0;
				held_valid = 1'b0;
				held_ticks = '0;
				held_high = 1'b0;
			end
			CMD_EDGE: begin
				if (cap_phase == PH_ARMED) begin
					tick_count = '0;
					cap_phase = PH_CAPTURE;
				end else if (cap_phase == PH_CAPTURE) begin
					d = tick_count;
					first_rec = (stored_records == '0);
					tick_count = '0;
					stored_records = stored_records + 8'd1;
					store_full = (int'(stored_records) >= 2 * PULSE_LIMIT);
					if (first_rec && tag) begin
						r.high_ticks = d;
						have_pair = 1'b1;
					end else if (held_valid) begin
						// Only a low record followed by a high one forms a real pair.
						if (!held_high && tag) begin
							r.low_ticks = held_ticks;
							r.high_ticks = d;
						end
						held_valid = 1'b0;
						have_pair = 1'b1;
					end else begin
						held_valid = 1'b1;
						held_ticks = d;
						held_high = tag;
					end
					if (have_pair) begin
						r.entry_valid = 1'b1;
						r.last = store_full;
						if (store_full)
							cap_phase = PH_IDLE;
						expected_pairs.push_back(r);
					end else if (store_full) begin
						close_capture();
					end
				end
			end
			CMD_TICK: begin
				if (cap_phase == PH_CAPTURE) begin
					if (tick_count != TICKS_MAX)
						tick_count = tick_count + 16'd1;
					if (tick_count >= idle_limit)
						close_capture();
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : drive_inputs
		ir_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_items.pop_front();
				in_valid <= 1'b1;
				cmd <= nxt.cmd;
				level_high <= nxt.tag;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin : watch_transfers
		result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_pairs.size() == 0) begin
					$error("result transfer with nothing expected: low %0d high %0d valid %0b last %0b",
						low_ticks, high_ticks, entry_valid, last);
					mismatch_count++;
				end else begin
					want = expected_pairs.pop_front();
					check_field("low_ticks", want.low_ticks, low_ticks);
					check_field("high_ticks", want.high_ticks, high_ticks);
					check_field("entry_valid", TIME_W'(want.entry_valid), TIME_W'(entry_valid));
					check_field("last", TIME_W'(want.last), TIME_W'(last));
				end
			end
			if (in_valid && !in_stall) begin
				accepted_count++;
				predict_capture(cmd, level_high);
			end
		end
	end

	function automatic logic coin();
		return $urandom_range(1) == 1;
	endfunction

	task automatic add_item(input logic [1:0] c, input logic t);
		ir_item_t it;
		it.cmd = c;
		it.tag = t;
		pending_items.push_back(it);
		queued_count++;
	endtask

	task automatic add_ticks(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			add_item(CMD_TICK, coin());
	endtask

	// Waits until every item has gone in and every result has come out.
	task automatic wait_quiet();
		while (accepted_count != queued_count || expected_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [TIME_W-1:0] value);
		wait_quiet();
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_data <= value;
		idle_limit = value;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// One burst: arm, first edge, a run of records that mostly alternate in level,
	// then usually enough silence to time out. A few records are flipped and a few
	// stray commands are mixed in.
	task automatic add_burst(input int unsigned tmo, input bit whole_store);
		int unsigned n_rec;
		int unsigned gap;
		logic lead_high;
		logic tag;
		logic [1:0] noise_cmd;
		add_item(CMD_START, coin());
		if ($urandom_range(3) == 0)
			add_ticks($urandom_range(1, 3));
		add_item(CMD_EDGE, coin());
		n_rec = whole_store ? 2 * PULSE_LIMIT : $urandom_range(1, 12);
		lead_high = coin();
		for (int unsigned r = 0; r < n_rec; r++) begin
			if (whole_store)
				gap = $urandom_range(0, (tmo > 2) ? 1 : tmo - 1);
			else if ($urandom_range(9) == 0)
				gap = tmo + $urandom_range(0, 1);
			else
				gap = $urandom_range(0, tmo - 1);
			add_ticks(gap);
			tag = lead_high ? (r % 2 == 0) : (r % 2 == 1);
			if ($urandom_range(9) == 0)
				tag = !tag;
			add_item(CMD_EDGE, tag);
			if (!whole_store && $urandom_range(19) == 0) begin
				noise_cmd = 2'($urandom_range(3));
				add_item(noise_cmd, coin());
			end
		end
		if ($urandom_range(3) != 0)
			add_ticks(tmo + $urandom_range(0, 2));
	endtask

	task automatic run_random_phase(input logic [TIME_W-1:0] tmo, input int unsigned idle_pct,
			input int unsigned stall_pct, input bit force_full);
		int unsigned phase_start;
		write_timeout(tmo);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		phase_start = queued_count;
		add_burst(32'(tmo), force_full);
		while (queued_count - phase_start < 40)
			add_burst(32'(tmo), 1'b0);
		// The sender holds off until the block has emptied out.
		wait_quiet();
		while (queued_count - phase_start < 80)
			add_burst(32'(tmo), 1'b0);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset timeout still in force. Commands while idle are ignored.
		add_item(CMD_EDGE, 1'b1);
		add_item(CMD_TICK, 1'b0);
		add_item(CMD_UNUSED, 1'b1);
		add_item(CMD_START, 1'b1);
		add_item(CMD_TICK, 1'b1);
		add_item(CMD_EDGE, 1'b0);
		add_ticks(3);
		add_item(CMD_EDGE, 1'b1);
		add_ticks(2);
		add_item(CMD_EDGE, 1'b0);
		add_ticks(5);
		add_item(CMD_EDGE, 1'b1);
		add_ticks(1);
		add_item(CMD_EDGE, 1'b1);
		add_item(CMD_EDGE, 1'b1);
		add_item(CMD_UNUSED, 1'b0);
		add_ticks(4);
		add_item(CMD_EDGE, 1'b0);
		// A new start drops the record still waiting for its partner.
		add_item(CMD_START, 1'b0);

		// A zero timeout ends the capture on its first tick.
		write_timeout('0);
		add_item(CMD_START, 1'b0);
		add_item(CMD_EDGE, 1'b1);
		add_item(CMD_TICK, 1'b0);

		write_timeout(16'd1);
		add_item(CMD_START, 1'b1);
		add_item(CMD_EDGE, 1'b0);
		add_item(CMD_EDGE, 1'b0);
		add_item(CMD_TICK, 1'b1);

		// A high record left over at the end still reports as (duration, 0).
		write_timeout(16'd3);
		add_item(CMD_START, 1'b0);
		add_item(CMD_EDGE, 1'b0);
		add_ticks(1);
		add_item(CMD_EDGE, 1'b0);
		add_ticks(2);
		add_item(CMD_EDGE, 1'b1);
		add_ticks(1);
		add_item(CMD_EDGE, 1'b1);
		add_ticks(3);

		run_random_phase(16'd16, 0, 0, 1'b1);
		run_random_phase(16'd5, 81, 0, 1'b0);
		run_random_phase(16'd8, 0, 81, 1'b0);
		run_random_phase(16'd2, 37, 37, 1'b0);

		wait_quiet();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/irpp_pkg.sv
rtl/irpp_front.sv
rtl/irpp_queue.sv
rtl/irpp_back.sv
rtl/ir_pulse_pair_capture.sv
tb/ir_pulse_pair_capture_tb.sv
